// ===== hw/rtl/jtag_shift_command_encoder_top_assert.svh =====
// Assertion macros for the command encoder checker.
// Included by the checker file; needs nothing else.
`ifndef JTAG_SHIFT_COMMAND_ENCODER_TOP_ASSERT_SVH
`define JTAG_SHIFT_COMMAND_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define JSCE_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JSCE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/jsce_pkg.sv =====
// Shared types, constants and helpers of the JTAG shift command encoder.
// No dependencies; the RTL modules and the bench files import it.
package jsce_pkg;

  localparam int MAX_SHIFT_BITS = 64;
  localparam int MAX_MOVE_BITS  = 32;

  localparam logic [6:0] MAX_SHIFT_CNT = 7'(MAX_SHIFT_BITS);
  localparam logic [6:0] MAX_MOVE_CNT  = 7'(MAX_MOVE_BITS);

  // MPSSE opcodes.
  localparam logic [7:0] OP_BYTES_RD = 8'h39;
  localparam logic [7:0] OP_BYTES    = 8'h19;
  localparam logic [7:0] OP_BITS_RD  = 8'h3b;
  localparam logic [7:0] OP_BITS     = 8'h1b;
  localparam logic [7:0] OP_TMS_RD   = 8'h6b;
  localparam logic [7:0] OP_TMS      = 8'h4b;
  localparam logic [7:0] OP_FLUSH    = 8'h87;
  localparam logic [5:0] TMS_MASK    = 6'h3f;

  localparam logic [2:0] CHUNK_BITS  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_BY_OP,
    ST_BY_LEN,
    ST_BY_ZERO,
    ST_BY_DATA,
    ST_CH_OP,
    ST_CH_LEN,
    ST_CH_DATA,
    ST_JM_OP,
    ST_JM_LEN,
    ST_JM_DATA,
    ST_FLUSH
  } st_t;

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       last;
    logic       error;
  } byte_t;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic [3:0] amt;
  } shctl_t;

  // Mask of the low n bits of a byte, n from 0 to 8.
  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [7:0] m;
    m = 8'hff;
    if (n < 4'd8) begin
      m = 8'((9'd1 << n) - 9'd1);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/jsce_if.sv =====
// Channel interfaces of the command encoder: request in, command byte out.
// Depends on nothing else.
interface jsce_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [6:0] bit_count;
  logic [63:0] data_bits;
  logic       read_back;
  logic [2:0] move_count;
  logic [5:0] move_bits;

  modport source (output valid, command, bit_count, data_bits, read_back,
                  move_count, move_bits, input ready);
  modport sink (input valid, command, bit_count, data_bits, read_back,
                move_count, move_bits, output ready);
endinterface

interface jsce_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       last;
  logic       error;

  modport source (output valid, cmd_byte, last, error, input ready);
  modport sink (input valid, cmd_byte, last, error, output ready);
endinterface

// ===== hw/rtl/jtag_shift_command_encoder_top.sv =====
// Top level of the JTAG shift command encoder.
// Depends on jsce_pkg, jsce_if, jsce_shreg, jsce_seq and jsce_obuf.
//
// Usage. A request arrives on the req channel as one transfer: a TMS move
// (command = 1, up to 32 bits) or a TDI shift (command = 0, up to 64 bits,
// optionally ending in a joined TMS move and with readback). The block answers
// on the rsp channel with the MPSSE command bytes of that request, one byte per
// transfer, with last set on the final byte. A request with bad counts gives a
// single transfer with error and last set and a zero byte. An empty TMS move
// is accepted and gives no transfer at all.
//
// Timing. req.ready is high only while no request is being walked, so one
// request is worked on at a time. After acceptance the sequencer state is
// registered, and each byte then passes through the output register; the bytes
// follow at one per cycle while the receiver keeps ready high, up to twenty per
// request. The rate is set by the sequencer, which produces one byte per cycle
// from a 64-bit shift register stepped by 8 or by up to 6 bits. An output
// register sits in front of rsp: while the receiver stalls it holds the byte
// steady and the sequencer waits. The next request is taken as soon as the last
// byte has entered that register.
//
// Reset (rst, synchronous, active high) returns the sequencer to idle and
// empties the output register; no other state needs clearing.
module jtag_shift_command_encoder_top (
  input  logic       clk,
  input  logic       rst,
  jsce_req_if.sink   req,
  jsce_rsp_if.source rsp
);
  import jsce_pkg::*;

  shctl_t     shctl;
  byte_t      item;
  logic       push;
  logic       space;
  logic [7:0] low_byte;

  // The sequencer owns the request handshake and decides every byte.
  jsce_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .space    (space),
    .low_byte (low_byte),
    .push     (push),
    .item     (item),
    .shctl    (shctl)
  );

  // Data bits are loaded at acceptance and shifted out as bytes or chunks.
  jsce_shreg u_shreg (
    .clk       (clk),
    .ctl       (shctl),
    .load_data (req.data_bits),
    .low_byte  (low_byte)
  );

  // Output register decouples the sequencer from a stalling receiver.
  jsce_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .space (space),
    .rsp   (rsp)
  );

endmodule

// ===== hw/rtl/jsce_shreg.sv =====
// Data shift register: holds the request's bits and shifts them out by digits.
// Depends on jsce_pkg.
module jsce_shreg (
  input  logic            clk,
  input  jsce_pkg::shctl_t ctl,
  input  logic [63:0]     load_data,
  output logic [7:0]      low_byte
);
  import jsce_pkg::*;

  logic [63:0] data;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.shift) begin
      data <= data >> ctl.amt;
    end
  end

  assign low_byte = data[7:0];

endmodule

// ===== hw/rtl/jsce_obuf.sv =====
// Output register between the sequencer and the byte channel.
// Depends on jsce_pkg and jsce_rsp_if.
module jsce_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsce_pkg::byte_t  item,
  output logic             space,
  jsce_rsp_if.source       rsp
);
  import jsce_pkg::*;

  logic  valid;
  byte_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= item;
    end
  end

  assign space        = !valid || rsp.ready;
  assign rsp.valid    = valid;
  assign rsp.cmd_byte = held.cmd_byte;
  assign rsp.last     = held.last;
  assign rsp.error    = held.error;

endmodule

// ===== hw/rtl/jsce_seq.sv =====
// Sequencer: decodes a request and walks its bytes one a cycle unless stalled.
// Depends on jsce_pkg and jsce_req_if.
module jsce_seq (
  input  logic              clk,
  input  logic              rst,
  jsce_req_if.sink          req,
  input  logic              space,
  input  logic [7:0]        low_byte,
  output logic              push,
  output jsce_pkg::byte_t   item,
  output jsce_pkg::shctl_t  shctl
);
  import jsce_pkg::*;

  st_t        state;
  st_t        state_next;
  st_t        base;
  st_t        first;
  st_t        after_chunks;
  logic       shift_mode;
  logic       rd;
  logic [2:0] mcount;
  logic [5:0] mbits;
  logic [5:0] left;
  logic [3:0] nby;
  logic [2:0] x;
  logic [5:0] left_after;
  logic       has_move;
  logic [6:0] eff;
  logic       accept;

  assign accept   = (state == ST_IDLE) && req.valid;
  assign req.ready = (state == ST_IDLE);
  assign has_move = (req.move_count != 3'd0);
  assign eff      = req.bit_count - {6'd0, has_move};
  assign x        = (left > {3'd0, CHUNK_BITS}) ? CHUNK_BITS : left[2:0];
  assign left_after = left - {3'd0, x};

  // Decode of a newly offered request.
  always_comb begin
    first = ST_IDLE;
    if (req.command) begin
      if (req.bit_count > MAX_MOVE_CNT) begin
        first = ST_ERR;
      end else if (req.bit_count != 7'd0) begin
        first = ST_CH_OP;
      end
    end else begin
      if (req.bit_count > MAX_SHIFT_CNT || (has_move && req.bit_count == 7'd0) ||
          eff == 7'd0 || req.move_count > 3'd6) begin
        first = ST_ERR;
      end else if (eff[6:3] != 4'd0) begin
        first = ST_BY_OP;
      end else begin
        first = ST_CH_OP;
      end
    end
  end

  always_comb begin
    after_chunks = ST_IDLE;
    if (shift_mode) begin
      if (mcount != 3'd0) begin
        after_chunks = ST_JM_OP;
      end else if (rd) begin
        after_chunks = ST_FLUSH;
      end
    end
  end

  // Next state.
  always_comb begin
    base = ST_IDLE;
    case (state)
      ST_IDLE:    base = first;
      ST_ERR:     base = ST_IDLE;
      ST_BY_OP:   base = ST_BY_LEN;
      ST_BY_LEN:  base = ST_BY_ZERO;
      ST_BY_ZERO: base = ST_BY_DATA;
      ST_BY_DATA: begin
        if (nby != 4'd1) begin
          base = ST_BY_DATA;
        end else if (left != 6'd0) begin
          base = ST_CH_OP;
        end else begin
          base = after_chunks;
        end
      end
      ST_CH_OP:   base = ST_CH_LEN;
      ST_CH_LEN:  base = ST_CH_DATA;
      ST_CH_DATA: base = (left_after != 6'd0) ? ST_CH_OP : after_chunks;
      ST_JM_OP:   base = ST_JM_LEN;
      ST_JM_LEN:  base = ST_JM_DATA;
      ST_JM_DATA: base = rd ? ST_FLUSH : ST_IDLE;
      ST_FLUSH:   base = ST_IDLE;
      default:    base = ST_IDLE;
    endcase
    if (state == ST_IDLE) begin
      state_next = req.valid ? first : ST_IDLE;
    end else begin
      state_next = space ? base : state;
    end
  end

  // Outputs.
  always_comb begin
    item.cmd_byte = 8'h00;
    item.last     = (base == ST_IDLE);
    item.error    = (state == ST_ERR);
    shctl.load    = accept;
    shctl.shift   = 1'b0;
    shctl.amt     = 4'd0;
    case (state)
      ST_IDLE:    item.cmd_byte = 8'h00;
      ST_ERR:     item.cmd_byte = 8'h00;
      ST_BY_OP:   item.cmd_byte = rd ? OP_BYTES_RD : OP_BYTES;
      ST_BY_LEN:  item.cmd_byte = {4'd0, nby - 4'd1};
      ST_BY_ZERO: item.cmd_byte = 8'h00;
      ST_BY_DATA: begin
        item.cmd_byte = low_byte;
        shctl.shift   = space;
        shctl.amt     = 4'd8;
      end
      ST_CH_OP: begin
        if (shift_mode) begin
          item.cmd_byte = rd ? OP_BITS_RD : OP_BITS;
        end else begin
          item.cmd_byte = OP_TMS;
        end
      end
      ST_CH_LEN:  item.cmd_byte = {5'd0, x - 3'd1};
      ST_CH_DATA: begin
        item.cmd_byte = low_byte & low_mask({1'b0, x});
        shctl.shift   = space;
        shctl.amt     = {1'b0, x};
      end
      ST_JM_OP:   item.cmd_byte = rd ? OP_TMS_RD : OP_TMS;
      ST_JM_LEN:  item.cmd_byte = {5'd0, mcount - 3'd1};
      ST_JM_DATA: item.cmd_byte = {low_byte[0], 1'b0, mbits & TMS_MASK};
      ST_FLUSH:   item.cmd_byte = OP_FLUSH;
      default:    item.cmd_byte = 8'h00;
    endcase
    push = (state != ST_IDLE) && space;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request fields and digit counters.
  always_ff @(posedge clk) begin
    if (accept) begin
      shift_mode <= !req.command;
      rd         <= req.read_back;
      mcount     <= req.move_count;
      mbits      <= req.move_bits;
      if (req.command) begin
        left <= req.bit_count[5:0];
        nby  <= 4'd0;
      end else begin
        left <= {3'd0, eff[2:0]};
        nby  <= eff[6:3];
      end
    end else if (space) begin
      if (state == ST_BY_DATA) begin
        nby <= nby - 4'd1;
      end
      if (state == ST_CH_DATA) begin
        left <= left_after;
      end
    end
  end

endmodule

// ===== hw/rtl/jsce_checker.sv =====
// Port-level checker for the command encoder, bound to the top level.
// Depends on jtag_shift_command_encoder_top_assert.svh.
`include "jtag_shift_command_encoder_top_assert.svh"

module jsce_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_command,
  input logic [6:0] req_bit_count,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_cmd_byte,
  input logic       rsp_last,
  input logic       rsp_error
);

  // An error result stands alone: it is the last byte and carries zero.
  `JSCE_ASSERT_NOW(a_err_alone, clk, rst, rsp_valid && rsp_error, rsp_last && rsp_cmd_byte == 8'h00, "error result without last or with nonzero byte")

  // Any request other than an empty move keeps the block busy afterwards.
  `JSCE_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready && !(req_command && req_bit_count == 7'd0), !req_ready, "request accepted while previous still in work")

  // A stalled byte stays on the channel unchanged.
  `JSCE_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cmd_byte) && $stable(rsp_last) && $stable(rsp_error), "stalled byte changed")

endmodule

bind jtag_shift_command_encoder_top jsce_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_command   (req.command),
  .req_bit_count (req.bit_count),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_cmd_byte  (rsp.cmd_byte),
  .rsp_last      (rsp.last),
  .rsp_error     (rsp.error)
);

// ===== bench/jsce_checker.sv =====
// Scoreboard for the JTAG shift command encoder: watches both channels, predicts
// the command bytes of each request and compares them with what the block sends.
// Depends on jsce_pkg and the channel interfaces in jsce_if.
module jsce_scoreboard (
  input  logic clk,
  input  logic rst,
  jsce_req_if  req,
  jsce_rsp_if  rsp,
  output int   failures,
  output int   outstanding,
  output int   bytes_checked,
  output int   rejects
);
  timeunit 1ns;
  timeprecision 1ps;
  import jsce_pkg::*;

  localparam int BYTE_LIMIT = 20;

  byte_t expected_bytes[$];
  int    fail_count = 0;
  int    wait_count = 0;
  int    byte_count = 0;
  int    reject_count = 0;

  assign failures      = fail_count;
  assign outstanding   = wait_count;
  assign bytes_checked = byte_count;
  assign rejects       = reject_count;

  // Appends one command byte unless the request has already filled its budget.
  function automatic int put_byte(input int n, input logic [7:0] b);
    if (n >= BYTE_LIMIT) begin
      return n;
    end
    expected_bytes.push_back('{cmd_byte: b, last: 1'b0, error: 1'b0});
    return n + 1;
  endfunction

  function automatic void push_reject();
    expected_bytes.push_back('{cmd_byte: 8'h00, last: 1'b1, error: 1'b1});
  endfunction

  function automatic void predict_commands(input logic cmd, input logic [6:0] cnt,
                                           input logic [63:0] bits, input logic rd,
                                           input logic [2:0] mc, input logic [5:0] mb);
    int          remaining;
    int          nbytes;
    int          x;
    int          n;
    logic [63:0] rest;
    byte_t       tail;
    n = 0;
    rest = bits;
    remaining = int'(cnt);
    if (cmd) begin
      if (cnt > MAX_MOVE_CNT) begin
        push_reject();
        return;
      end
      while (remaining > 0) begin
        x = (remaining > int'(CHUNK_BITS)) ? int'(CHUNK_BITS) : remaining;
        n = put_byte(n, OP_TMS);
        n = put_byte(n, 8'(x - 1));
        n = put_byte(n, 8'(rest & ((64'd1 << x) - 64'd1)));
        rest = rest >> x;
        remaining -= x;
      end
    end else begin
      if (cnt > MAX_SHIFT_CNT) begin
        push_reject();
        return;
      end
      // The last TDI bit travels inside the joined TMS move.
      if (mc != 3'd0) begin
        if (remaining == 0) begin
          push_reject();
          return;
        end
        remaining--;
      end
      if (remaining == 0 || mc > CHUNK_BITS) begin
        push_reject();
        return;
      end
      nbytes = remaining / 8;
      if (nbytes > 0) begin
        remaining -= nbytes * 8;
        n = put_byte(n, rd ? OP_BYTES_RD : OP_BYTES);
        n = put_byte(n, 8'(nbytes - 1));
        n = put_byte(n, 8'h00);
        for (int i = 0; i < nbytes; i++) begin
          n = put_byte(n, rest[7:0]);
          rest = rest >> 8;
        end
      end
      while (remaining > 0) begin
        x = (remaining > int'(CHUNK_BITS)) ? int'(CHUNK_BITS) : remaining;
        n = put_byte(n, rd ? OP_BITS_RD : OP_BITS);
        n = put_byte(n, 8'(x - 1));
        n = put_byte(n, 8'(rest & ((64'd1 << x) - 64'd1)));
        rest = rest >> x;
        remaining -= x;
      end
      if (mc != 3'd0) begin
        n = put_byte(n, rd ? OP_TMS_RD : OP_TMS);
        n = put_byte(n, 8'(mc - 3'd1));
        n = put_byte(n, {rest[0], 1'b0, mb & TMS_MASK});
      end
      if (rd) begin
        n = put_byte(n, OP_FLUSH);
      end
    end
    if (n > 0) begin
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  // Responses are checked before the request of the same edge is predicted, since
  // a byte can never belong to a request accepted at that very edge.
  always @(posedge clk) begin : watch
    byte_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transfer: expected none, actual byte %02h last %0b error %0b",
                   $time, rsp.cmd_byte, rsp.last, rsp.error);
        end else begin
          want = expected_bytes.pop_front();
          byte_count++;
          if (rsp.error === 1'b1) begin
            reject_count++;
          end
          if (rsp.cmd_byte !== want.cmd_byte) begin
            fail_count++;
            $display("%0t: cmd_byte mismatch: expected %02h, actual %02h",
                     $time, want.cmd_byte, rsp.cmd_byte);
          end
          if (rsp.last !== want.last) begin
            fail_count++;
            $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, rsp.last);
          end
          if (rsp.error !== want.error) begin
            fail_count++;
            $display("%0t: error mismatch: expected %0b, actual %0b",
                     $time, want.error, rsp.error);
          end
        end
      end
      if (req.valid && req.ready) begin
        predict_commands(req.command, req.bit_count, req.data_bits, req.read_back,
                         req.move_count, req.move_bits);
      end
      wait_count = expected_bytes.size();
    end
  end

endmodule

// ===== bench/jtag_shift_command_encoder_top_test.sv =====
// Top of the command encoder testbench: clock, reset, request stimulus and the
// receiver's stalls. Depends on jsce_pkg, jsce_if, jsce_checker and the block.
module jtag_shift_command_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jsce_pkg::*;

  // Roughly 225 requests of at most twenty bytes, each byte possibly held up by a
  // receiver stall, fit well within the watchdog limit.
  localparam int RANDOM_ITEMS = 200;
  localparam int CYCLE_LIMIT  = 800_000;
  localparam int DRAIN_CYCLES = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jsce_req_if req ();
  jsce_rsp_if rsp ();

  int failures;
  int outstanding;
  int bytes_checked;
  int rejects;

  int cycle_count = 0;
  int stall_left = 0;
  int calm_left = 0;
  logic calm = 1'b0;
  int moves_sent = 0;
  int shifts_sent = 0;

  jtag_shift_command_encoder_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  jsce_scoreboard checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .failures      (failures),
    .outstanding   (outstanding),
    .bytes_checked (bytes_checked),
    .rejects       (rejects)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that has not finished by now has hung somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("jtag_shift_command_encoder_top_test: errors");
      $finish;
    end
  end

  // Most gaps are drawn from the lower range; now and then one is long enough to let the
  // other side run dry or fill up completely.
  function automatic int random_gap();
    if ($urandom_range(0, 9) < 7) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Calm stretches switch idling off on both sides, so that back-to-back
  // transfers are exercised as well as the stalled ones.
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(30, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // The receiver: ready drops for stretches of random length outside calm spells.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      rsp.ready <= 1'b0;
      stall_left <= random_gap() - 1;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Offers one request and returns at the edge where its transfer takes place.
  // Valid stays high between requests that follow without a gap.
  task automatic send_request(input logic cmd, input logic [6:0] cnt, input logic [63:0] bits,
                              input logic rd, input logic [2:0] mc, input logic [5:0] mb);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 2) == 0) begin
      gap = random_gap();
    end
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.command    <= cmd;
    req.bit_count  <= cnt;
    req.data_bits  <= bits;
    req.read_back  <= rd;
    req.move_count <= mc;
    req.move_bits  <= mb;
    do @(posedge clk); while (req.ready !== 1'b1);
    if (cmd) begin
      moves_sent++;
    end else begin
      shifts_sent++;
    end
  endtask

  initial begin
    int          counted;
    int          pick;
    logic        cmd;
    logic [6:0]  cnt;
    logic [63:0] bits;
    logic        rd;
    logic [2:0]  mc;
    logic [5:0]  mb;

    req.valid      = 1'b0;
    req.command    = 1'b0;
    req.bit_count  = '0;
    req.data_bits  = '0;
    req.read_back  = 1'b0;
    req.move_count = '0;
    req.move_bits  = '0;
    rsp.ready      = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. TMS moves first: empty, single bit, one full chunk, a chunk
    // and a bit, the longest legal move, and moves that are too long. The joined
    // move fields and readback mean nothing to a TMS move.
    send_request(1'b1, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 3'd0, 6'd0);
    send_request(1'b1, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 3'd0, 6'd0);
    send_request(1'b1, 7'd6, 64'h0000_0000_0000_002A, 1'b1, 3'd7, 6'h3F);
    send_request(1'b1, 7'd7, 64'h0000_0000_0000_0055, 1'b0, 3'd0, 6'd0);
    send_request(1'b1, 7'd32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 3'd3, 6'h15);
    send_request(1'b1, 7'd33, 64'h0123_4567_89AB_CDEF, 1'b0, 3'd0, 6'd0);
    send_request(1'b1, 7'd127, 64'h0, 1'b1, 3'd0, 6'd0);

    // TDI shifts: the empty shift, a single bit, a single bit that is taken by the
    // joined move and leaves nothing to shift, the smallest shift with a joined
    // move, whole bytes only, the widest shift with and without readback, the
    // widest shift ending in the longest joined move, shifts that are too long and
    // a joined move that is too long. Bits above the count are set to show that
    // they are ignored.
    send_request(1'b0, 7'd0, 64'h0, 1'b0, 3'd0, 6'd0);
    send_request(1'b0, 7'd1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 3'd0, 6'd0);
    send_request(1'b0, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'd1, 6'h01);
    send_request(1'b0, 7'd2, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 3'd1, 6'h3F);
    send_request(1'b0, 7'd8, 64'hFFFF_FFFF_FFFF_FF5A, 1'b0, 3'd0, 6'd0);
    send_request(1'b0, 7'd9, 64'hFFFF_FFFF_FFFF_FF80, 1'b1, 3'd1, 6'h2A);
    send_request(1'b0, 7'd64, 64'h8000_0000_0000_0001, 1'b0, 3'd0, 6'd0);
    send_request(1'b0, 7'd64, 64'hA5A5_5A5A_F0F0_0F0F, 1'b1, 3'd0, 6'd0);
    send_request(1'b0, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'd6, 6'h3F);
    send_request(1'b0, 7'd64, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 3'd6, 6'h00);
    send_request(1'b0, 7'd13, 64'hFFFF_FFFF_FFFF_E000, 1'b1, 3'd0, 6'd0);
    send_request(1'b0, 7'd7, 64'h0000_0000_0000_007F, 1'b0, 3'd0, 6'd0);
    send_request(1'b0, 7'd65, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 3'd0, 6'd0);
    send_request(1'b0, 7'd127, 64'h0, 1'b1, 3'd2, 6'd5);
    send_request(1'b0, 7'd20, 64'h0000_0000_000F_FFFF, 1'b0, 3'd7, 6'h3F);
    send_request(1'b0, 7'd0, 64'h0, 1'b0, 3'd4, 6'd9);

    // Random part: mostly legal requests with random content, the rest random
    // counts that may well be rejected. Empty moves pass through but are not
    // counted, since they give nothing to check.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      cmd  = 1'($urandom_range(0, 1));
      bits = {$urandom(), $urandom()};
      rd   = 1'($urandom_range(0, 1));
      mb   = 6'($urandom_range(0, 63));
      mc   = 3'($urandom_range(0, 7));
      if (pick < 88) begin
        if (cmd) begin
          cnt = 7'($urandom_range(1, MAX_MOVE_BITS));
        end else begin
          mc  = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(1, 6));
          cnt = 7'($urandom_range((mc != 3'd0) ? 2 : 1, MAX_SHIFT_BITS));
        end
      end else begin
        cnt = 7'($urandom_range(0, 127));
      end
      send_request(cmd, cnt, bits, rd, mc, mb);
      if (!(cmd && cnt == 7'd0)) begin
        counted++;
      end
    end
    req.valid <= 1'b0;

    // Wait for the last bytes at falling edges, where the checker has settled,
    // then give the block time to show any stray transfer.
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d TMS moves and %0d TDI shifts; %0d command bytes checked, %0d rejections.",
             moves_sent, shifts_sent, bytes_checked, rejects);
    if (failures == 0) begin
      $display("jtag_shift_command_encoder_top_test: clean");
    end else begin
      $display("jtag_shift_command_encoder_top_test: errors");
    end
    $finish;
  end

endmodule
